[rtl/core/rti_pkg.sv]
package rti_pkg;

  localparam int COORD_WIDTH    = 21;
  localparam int FRAC_BITS      = 12;
  localparam int DIR_WIDTH      = 16;
  localparam int DIR_FRAC       = 14;
  localparam int DIST_WIDTH     = 22;
  localparam int DIV_STEPS      = DIST_WIDTH;
  localparam int DEN_WIDTH      = 2 * DIR_WIDTH + 2;
  localparam int SPEC_EPS_SHIFT = 2 * DIR_FRAC - FRAC_BITS;
  localparam int CFG_ADDR_WIDTH = 6;
  localparam int CFG_DATA_WIDTH = 64;
  localparam int VTX_WIDTH      = 3 * COORD_WIDTH;
  localparam int NRM_WIDTH      = 3 * DIR_WIDTH;
  localparam int EPS_WIDTH      = 12;
  localparam int OFS_WIDTH      = 24;

  localparam logic [DIST_WIDTH-1:0] DIST_INF  = '1;
  localparam logic [DIST_WIDTH-1:0] DIST_MAX  = DIST_INF - 1'b1;
  localparam logic [EPS_WIDTH-1:0]  EPS_RESET = 12'd4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIR_WIDTH-1:0]   dir_t;
  typedef logic [DIST_WIDTH-1:0]         dist_t;

  typedef enum logic [2:0] {
    REG_VERTEX_A     = 3'd0,
    REG_VERTEX_B     = 3'd1,
    REG_VERTEX_C     = 3'd2,
    REG_UNIT_NORMAL  = 3'd3,
    REG_PLANE_OFFSET = 3'd4,
    REG_NEAR_EPSILON = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [VTX_WIDTH-1:0] org;
    logic [NRM_WIDTH-1:0] dir;
    dist_t                maxd;
    logic                 miss;
    logic                 ovf;
  } side_t;

  function automatic coord_t crd(input logic [VTX_WIDTH-1:0] v, input int i);
    return v[i*COORD_WIDTH +: COORD_WIDTH];
  endfunction

  function automatic dir_t dcomp(input logic [NRM_WIDTH-1:0] v, input int i);
    return v[i*DIR_WIDTH +: DIR_WIDTH];
  endfunction

endpackage

[rtl/core/rti_in_if.sv]
interface rti_in_if import rti_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t origin_x;
  coord_t origin_y;
  coord_t origin_z;
  dir_t   dir_x;
  dir_t   dir_y;
  dir_t   dir_z;
  dist_t  max_distance;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance,
    output ready
  );
endinterface

[rtl/core/rti_out_if.sv]
interface rti_out_if import rti_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  hit;
  dist_t hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink (input valid, hit, hit_distance, output ready);
endinterface

[rtl/core/rti_mul.sv]
module rti_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int KA = WA / 2;
  localparam int KB = WB / 2;
  localparam int PW = WA + WB;

  logic signed [WA-KA-1:0] ah;
  logic signed [KA:0]      al;
  logic signed [WB-KB-1:0] bh;
  logic signed [KB:0]      bl;

  logic signed [WA-KA+WB-KB-1:0] hh_r;
  logic signed [WA-KA+KB:0]      hl_r;
  logic signed [KA+WB-KB:0]      lh_r;
  logic signed [KA+KB+1:0]       ll_r;
  logic signed [PW-1:0]          p_r;

  assign ah = a[WA-1:KA];
  assign al = $signed({1'b0, a[KA-1:0]});
  assign bh = b[WB-1:KB];
  assign bl = $signed({1'b0, b[KB-1:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= ah * bh;
      hl_r <= ah * bl;
      lh_r <= al * bh;
      ll_r <= al * bl;
      p_r  <= (PW'(hh_r) <<< (KA + KB)) + (PW'(hl_r) <<< KA) + (PW'(lh_r) <<< KB)
              + PW'(ll_r);
    end
  end

  assign p = p_r;

endmodule

[rtl/core/rti_div.sv]
module rti_div import rti_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_v,
  input  side_t                 in_side,
  input  logic [DEN_WIDTH-1:0]  in_rem,
  input  logic [DEN_WIDTH-1:0]  in_den,
  input  logic [DIST_WIDTH-1:0] in_low,
  output logic                  out_v,
  output side_t                 out_side,
  output logic [DIST_WIDTH-1:0] out_q
);

  typedef struct packed {
    side_t                 side;
    logic [DEN_WIDTH-1:0]  rem;
    logic [DEN_WIDTH-1:0]  den;
    logic [DIST_WIDTH-1:0] low;
    logic [DIST_WIDTH-1:0] q;
  } div_t;

  div_t                 src [DIV_STEPS];
  div_t                 st_nxt [DIV_STEPS];
  div_t                 st_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] v_r;

  function automatic div_t step(input div_t s);
    logic [DEN_WIDTH:0] sh;
    logic               ge;
    div_t               r;
    r     = s;
    sh    = {s.rem, s.low[DIST_WIDTH-1]};
    ge    = sh >= {1'b0, s.den};
    r.rem = ge ? DEN_WIDTH'(sh - {1'b0, s.den}) : DEN_WIDTH'(sh);
    r.low = s.low << 1;
    r.q   = {s.q[DIST_WIDTH-2:0], ge};
    return r;
  endfunction

  always_comb begin
    src[0] = '{side: in_side, rem: in_rem, den: in_den, low: in_low, q: '0};
    for (int k = 1; k < DIV_STEPS; k++) begin
      src[k] = st_r[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      st_nxt[k] = step(src[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STEPS-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_v    = v_r[DIV_STEPS-1];
  assign out_side = st_r[DIV_STEPS-1].side;
  assign out_q    = st_r[DIV_STEPS-1].q;

endmodule

[rtl/core/ray_triangle_intersect.sv]
// channel   direction  handshake           word
// in_ch     sink       valid / ready       origin_x/y/z, dir_x/y/z, max_distance
// out_ch    source     valid / ready       hit, hit_distance
// apb       slave      psel/penable/pready 64-bit registers at 8*index
//
// one ray per cycle while the skid word is empty; the whole pipeline stalls while it is full
// a ray passes through the 22-step distance divider plus 17 arithmetic stages
// rst_n is synchronous; it clears valid bits and loads register resets
// one skid word behind the output register; ready drops only when it is full

module ray_triangle_intersect import rti_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  rti_in_if.sink                    in_ch,
  rti_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output logic [CFG_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  localparam int ODW   = COORD_WIDTH + DIR_WIDTH;
  localparam int DIFFW = ODW + 3;
  localparam int DPROD = 2 * DIR_WIDTH;
  localparam int EW    = COORD_WIDTH + 1;
  localparam int SQP   = 2 * EW;
  localparam int SQW   = SQP + 2;
  localparam int GPW   = 2 * SQW;
  localparam int GW    = GPW + 1;
  localparam int TDW   = DIST_WIDTH + 1 + DIR_WIDTH;
  localparam int OAW   = EW + DIR_FRAC;
  localparam int APW   = TDW + 1;
  localparam int PBW   = EW + APW;
  localparam int DPW   = PBW + 2;
  localparam int UPW   = DPW + SQW;
  localparam int UW    = UPW + 1;
  localparam int UVW   = UW + 1;
  localparam int GBW   = GW + DIR_FRAC;
  localparam int FW    = UVW + 2;
  localparam int FMA   = DIST_WIDTH + 1;
  localparam int FMB   = DEN_WIDTH + 1;
  localparam int FPW   = FMA + FMB;
  localparam int LOWB  = DIST_WIDTH - DIR_FRAC;
  localparam int OVW   = DEN_WIDTH + LOWB;

  typedef struct packed {
    logic [VTX_WIDTH-1:0] org;
    logic [NRM_WIDTH-1:0] dir;
    dist_t                maxd;
    logic                 miss;
    dist_t                t;
  } post_t;

  // configuration
  logic [VTX_WIDTH-1:0]        vtx_a_r, vtx_b_r, vtx_c_r;
  logic [NRM_WIDTH-1:0]        nrm_r;
  logic signed [OFS_WIDTH-1:0] po_r;
  logic [EPS_WIDTH-1:0]        eps_r;
  logic                        wr;
  reg_idx_t                    idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_WIDTH-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_a_r <= '0;
      vtx_b_r <= '0;
      vtx_c_r <= '0;
      nrm_r   <= '0;
      po_r    <= '0;
      eps_r   <= EPS_RESET;
    end else if (wr) begin
      case (idx)
        REG_VERTEX_A:     vtx_a_r <= pwdata[VTX_WIDTH-1:0];
        REG_VERTEX_B:     vtx_b_r <= pwdata[VTX_WIDTH-1:0];
        REG_VERTEX_C:     vtx_c_r <= pwdata[VTX_WIDTH-1:0];
        REG_UNIT_NORMAL:  nrm_r   <= pwdata[NRM_WIDTH-1:0];
        REG_PLANE_OFFSET: po_r    <= pwdata[OFS_WIDTH-1:0];
        REG_NEAR_EPSILON: eps_r   <= pwdata[EPS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VERTEX_A:     prdata = CFG_DATA_WIDTH'(vtx_a_r);
      REG_VERTEX_B:     prdata = CFG_DATA_WIDTH'(vtx_b_r);
      REG_VERTEX_C:     prdata = CFG_DATA_WIDTH'(vtx_c_r);
      REG_UNIT_NORMAL:  prdata = CFG_DATA_WIDTH'(nrm_r);
      REG_PLANE_OFFSET: prdata = CFG_DATA_WIDTH'({po_r});
      REG_NEAR_EPSILON: prdata = CFG_DATA_WIDTH'(eps_r);
      default:          prdata = '0;
    endcase
  end

  // edge terms from the vertex registers, free running
  logic signed [EW-1:0]  ab_r [3];
  logic signed [EW-1:0]  ac_r [3];
  logic signed [SQP-1:0] bb_r [3];
  logic signed [SQP-1:0] cc_r [3];
  logic signed [SQP-1:0] bc_r [3];
  logic signed [SQW-1:0] dbb_r, dcc_r, dbc_r;
  logic signed [GPW-1:0] g1, g2;
  logic signed [GW-1:0]  gram_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ab_r[i] <= EW'(crd(vtx_b_r, i)) - EW'(crd(vtx_a_r, i));
      ac_r[i] <= EW'(crd(vtx_c_r, i)) - EW'(crd(vtx_a_r, i));
      bb_r[i] <= ab_r[i] * ab_r[i];
      cc_r[i] <= ac_r[i] * ac_r[i];
      bc_r[i] <= ab_r[i] * ac_r[i];
    end
    dbb_r  <= SQW'(bb_r[0]) + SQW'(bb_r[1]) + SQW'(bb_r[2]);
    dcc_r  <= SQW'(cc_r[0]) + SQW'(cc_r[1]) + SQW'(cc_r[2]);
    dbc_r  <= SQW'(bc_r[0]) + SQW'(bc_r[1]) + SQW'(bc_r[2]);
    gram_r <= GW'(g1) - GW'(g2);
  end

  rti_mul #(.WA(SQW), .WB(SQW)) u_g1 (.clk(clk), .en(1'b1), .a(dbb_r), .b(dcc_r), .p(g1));
  rti_mul #(.WA(SQW), .WB(SQW)) u_g2 (.clk(clk), .en(1'b1), .a(dbc_r), .b(dbc_r), .p(g2));

  // pipeline control
  logic        en;
  logic        out_v_r, skid_v_r;
  logic        out_hit_r, skid_hit_r;
  dist_t       out_dist_r, skid_dist_r;
  logic [6:1]  pv_r;
  logic [16:7] qv_r;
  logic        hv_r;
  logic        hit17_r;
  dist_t       dist17_r;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // plane stages
  logic [VTX_WIDTH-1:0]    org_in;
  logic [NRM_WIDTH-1:0]    dir_in;
  side_t                   sa_r [1:6];
  logic signed [ODW-1:0]   on_r [3];
  logic signed [DPROD-1:0] dn_r [3];
  logic signed [DIFFW-1:0] diff_r;
  logic signed [DEN_WIDTH-1:0] spec_r;
  logic [DIFFW-1:0]        mdiff_c;
  logic [DEN_WIDTH-1:0]    mspec_c;
  logic                    miss_c;
  logic [DIFFW-1:0]        md_r [3:6];
  logic [DEN_WIDTH-1:0]    ms_r [3:6];
  logic signed [FPW-1:0]   farp;
  logic                    far_c, ovf_c;

  assign org_in = {in_ch.origin_z, in_ch.origin_y, in_ch.origin_x};
  assign dir_in = {in_ch.dir_z, in_ch.dir_y, in_ch.dir_x};

  always_comb begin
    mdiff_c = diff_r[DIFFW-1] ? DIFFW'(-diff_r) : DIFFW'(diff_r);
    mspec_c = spec_r[DEN_WIDTH-1] ? DEN_WIDTH'(-spec_r) : DEN_WIDTH'(spec_r);
    miss_c  = (mdiff_c < (DIFFW'(eps_r) << DIR_FRAC))
           || (spec_r == '0)
           || (mspec_c < (DEN_WIDTH'(eps_r) << SPEC_EPS_SHIFT))
           || ((diff_r != '0) && (diff_r[DIFFW-1] != spec_r[DEN_WIDTH-1]));
    far_c   = (sa_r[5].maxd != DIST_INF)
           && (FPW'({md_r[5], DIR_FRAC'(0)}) > $unsigned(farp));
    ovf_c   = OVW'(md_r[5]) >= {ms_r[5], LOWB'(0)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r[1] <= '{org: org_in, dir: dir_in, maxd: in_ch.max_distance, miss: 1'b0,
                   ovf: 1'b0};
      for (int i = 0; i < 3; i++) begin
        on_r[i] <= crd(org_in, i) * dcomp(nrm_r, i);
        dn_r[i] <= dcomp(dir_in, i) * dcomp(nrm_r, i);
      end
      sa_r[2] <= sa_r[1];
      diff_r  <= (DIFFW'(po_r) <<< DIR_FRAC)
               - (DIFFW'(on_r[0]) + DIFFW'(on_r[1]) + DIFFW'(on_r[2]));
      spec_r  <= DEN_WIDTH'(dn_r[0]) + DEN_WIDTH'(dn_r[1]) + DEN_WIDTH'(dn_r[2]);
      sa_r[3] <= '{org: sa_r[2].org, dir: sa_r[2].dir, maxd: sa_r[2].maxd, miss: miss_c,
                   ovf: sa_r[2].ovf};
      md_r[3] <= mdiff_c;
      ms_r[3] <= mspec_c;
      for (int k = 4; k <= 6; k++) begin
        md_r[k] <= md_r[k-1];
        ms_r[k] <= ms_r[k-1];
      end
      sa_r[4] <= sa_r[3];
      sa_r[5] <= sa_r[4];
      sa_r[6] <= '{org: sa_r[5].org, dir: sa_r[5].dir, maxd: sa_r[5].maxd,
                   miss: sa_r[5].miss | far_c, ovf: ovf_c};
    end
  end

  rti_mul #(.WA(FMA), .WB(FMB)) u_far (
    .clk(clk), .en(en),
    .a($signed({1'b0, sa_r[3].maxd})), .b($signed({1'b0, ms_r[3]})), .p(farp)
  );

  // distance divider
  logic                  div_v;
  side_t                 div_side;
  logic [DIST_WIDTH-1:0] div_q;

  rti_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(pv_r[6]), .in_side(sa_r[6]),
    .in_rem(DEN_WIDTH'(md_r[6][DIFFW-1:LOWB])),
    .in_den(ms_r[6]),
    .in_low({md_r[6][LOWB-1:0], DIR_FRAC'(0)}),
    .out_v(div_v), .out_side(div_side), .out_q(div_q)
  );

  // hit point and edge weights
  post_t                 sb_r [7:16];
  logic signed [TDW-1:0] td_r [3];
  logic signed [OAW-1:0] oa_r [3];
  logic signed [APW-1:0] ap_r [3];
  logic signed [PBW-1:0] pb [3];
  logic signed [PBW-1:0] pc [3];
  logic signed [DPW-1:0] dbp_r, dcp_r;
  logic signed [UPW-1:0] pu1, pu2, pv1, pv2;
  logic signed [UW-1:0]  u_r, v_r;
  logic signed [UVW-1:0] uv_r;
  logic                  un_r, vn_r;
  logic signed [FW-1:0]  fin_c;
  logic                  hit_c;

  always_comb begin
    fin_c = FW'(GBW'(gram_r) <<< DIR_FRAC) - FW'(uv_r);
    hit_c = !sb_r[16].miss && !gram_r[GW-1] && (gram_r != '0) && !un_r && !vn_r
         && !fin_c[FW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[7] <= '{org: div_side.org, dir: div_side.dir, maxd: div_side.maxd,
                   miss: div_side.miss,
                   t: (div_side.ovf || div_q == DIST_INF) ? DIST_MAX : div_q};
      for (int k = 8; k <= 16; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        td_r[i] <= $signed({1'b0, sb_r[7].t}) * dcomp(sb_r[7].dir, i);
        oa_r[i] <= (OAW'(crd(sb_r[7].org, i)) - OAW'(crd(vtx_a_r, i))) <<< DIR_FRAC;
        ap_r[i] <= APW'(oa_r[i]) + APW'(td_r[i]);
      end
      dbp_r    <= DPW'(pb[0]) + DPW'(pb[1]) + DPW'(pb[2]);
      dcp_r    <= DPW'(pc[0]) + DPW'(pc[1]) + DPW'(pc[2]);
      u_r      <= UW'(pu1) - UW'(pu2);
      v_r      <= UW'(pv1) - UW'(pv2);
      uv_r     <= UVW'(u_r) + UVW'(v_r);
      un_r     <= u_r[UW-1];
      vn_r     <= v_r[UW-1];
      hit17_r  <= hit_c;
      dist17_r <= hit_c ? sb_r[16].t : sb_r[16].maxd;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_edge
    rti_mul #(.WA(EW), .WB(APW)) u_pb (
      .clk(clk), .en(en), .a(ab_r[i]), .b(ap_r[i]), .p(pb[i])
    );
    rti_mul #(.WA(EW), .WB(APW)) u_pc (
      .clk(clk), .en(en), .a(ac_r[i]), .b(ap_r[i]), .p(pc[i])
    );
  end

  rti_mul #(.WA(DPW), .WB(SQW)) u_u1 (.clk(clk), .en(en), .a(dbp_r), .b(dcc_r), .p(pu1));
  rti_mul #(.WA(DPW), .WB(SQW)) u_u2 (.clk(clk), .en(en), .a(dcp_r), .b(dbc_r), .p(pu2));
  rti_mul #(.WA(DPW), .WB(SQW)) u_v1 (.clk(clk), .en(en), .a(dcp_r), .b(dbb_r), .p(pv1));
  rti_mul #(.WA(DPW), .WB(SQW)) u_v2 (.clk(clk), .en(en), .a(dbp_r), .b(dbc_r), .p(pv2));

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      qv_r <= '0;
      hv_r <= 1'b0;
    end else if (en) begin
      pv_r <= {pv_r[5:1], in_ch.valid};
      qv_r <= {qv_r[15:7], div_v};
      hv_r <= qv_r[16];
    end
  end

  // output register and skid word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= en && hv_r;
      end
    end else if (en && hv_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_hit_r  <= skid_hit_r;
        out_dist_r <= skid_dist_r;
      end else begin
        out_hit_r  <= hit17_r;
        out_dist_r <= dist17_r;
      end
    end else if (en && hv_r) begin
      skid_hit_r  <= hit17_r;
      skid_dist_r <= dist17_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.hit_distance = out_dist_r;

  a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held without output word");

  a_skid_fill : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready))
    else $error("skid filled while output was free");

  a_hit_finite : assert property (@(posedge clk) disable iff (!rst_n)
    (hv_r && hit17_r) |-> (dist17_r != DIST_INF))
    else $error("hit with infinite distance");

endmodule
